>>> sv/tmhq_pkg.sv
// ----------------------------------------------------------------------------
// tmhq_pkg
// shared constants, types and codes of the timer heap queue
// ----------------------------------------------------------------------------
package tmhq_pkg;

	localparam int HEAP_DEPTH = 64;
	localparam int TIMER_IDS  = 256;
	localparam int HW = $clog2(HEAP_DEPTH);      // heap index width
	localparam int SW = $clog2(HEAP_DEPTH + 1);  // heap size width
	localparam int IW = $clog2(TIMER_IDS);       // id table index width

	// one heap entry
	typedef struct packed {
		logic [63:0] expiry;
		logic [7:0]  timer;
		logic [16:0] remaining;
		logic [31:0] period;
		logic        stopped;
	} entry_t;

	localparam int EW = $bits(entry_t);

	// item modes
	localparam logic [1:0] MODE_ADD  = 2'd0;
	localparam logic [1:0] MODE_STOP = 2'd1;

	// result status codes
	localparam logic [3:0] ST_ADDED     = 4'd0;
	localparam logic [3:0] ST_FULL      = 4'd1;
	localparam logic [3:0] ST_ACTIVE    = 4'd2;
	localparam logic [3:0] ST_STOPPED   = 4'd3;
	localparam logic [3:0] ST_UNKNOWN   = 4'd4;
	localparam logic [3:0] ST_NOT_DUE   = 4'd5;
	localparam logic [3:0] ST_REARMED   = 4'd6;
	localparam logic [3:0] ST_FINAL     = 4'd7;
	localparam logic [3:0] ST_DISCARDED = 4'd8;

endpackage

>>> sv/tmhq_ram.sv
// ----------------------------------------------------------------------------
// tmhq_ram
// generic single-port synchronous ram with registered read
// ----------------------------------------------------------------------------
module tmhq_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read first, registered read
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end

endmodule

>>> sv/timer_min_heap_queue.sv
// ----------------------------------------------------------------------------
// timer_min_heap_queue
// timer queue in a binary min-heap memory, with add, stop and tick items
// ----------------------------------------------------------------------------
//  channel | signals                                            | direction
//  in      | in_valid in_ready mode timer_id delay_ms           | in
//          | interval_ms repeat_count now_ns                    |
//  out     | out_valid out_ready status fired fired_id          | out
//
// one item at a time; the heap lives in a single-port ram (one access a cycle)
// add: each heap level sifted up takes a parent read, then a compare and a write
// stop: linear scan, a read and a compare per entry, up to heap size
// tick: pop sifts down, reading both children then comparing and copying at each level, then an optional re-arm push
// reset clears heap size and the id table valid bits at once; no clearing pass
// the result waits in an output register; the next item is taken once it leaves
module timer_min_heap_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [7:0]  timer_id,
	input  logic [31:0] delay_ms,
	input  logic [31:0] interval_ms,
	input  logic signed [16:0] repeat_count,
	input  logic [62:0] now_ns,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  status,
	output logic        fired,
	output logic [7:0]  fired_id
);

	localparam int HW = tmhq_pkg::HW;
	localparam int SW = tmhq_pkg::SW;

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_ADD   = 5'd1;
	localparam logic [4:0] S_UPRD  = 5'd2;  // parent read issued
	localparam logic [4:0] S_UPCMP = 5'd3;  // parent data valid
	localparam logic [4:0] S_STRD  = 5'd4;
	localparam logic [4:0] S_STCMP = 5'd5;
	localparam logic [4:0] S_TKRD  = 5'd6;
	localparam logic [4:0] S_TKCMP = 5'd7;
	localparam logic [4:0] S_LSTRD = 5'd8;  // read last entry
	localparam logic [4:0] S_LSTGT = 5'd9;
	localparam logic [4:0] S_DNC1  = 5'd10; // first child read issued
	localparam logic [4:0] S_DNC2  = 5'd11; // second child data
	localparam logic [4:0] S_DNDEC = 5'd12;
	localparam logic [4:0] S_DNCP  = 5'd13; // child copy written
	localparam logic [4:0] S_AFTER = 5'd14; // after pop: discard, fire or rearm
	localparam logic [4:0] S_OUT   = 5'd15;
	localparam logic [4:0] S_DNRD2 = 5'd16;

	logic [4:0]  state_q;
	logic [SW-1:0] size_q;
	logic [tmhq_pkg::TIMER_IDS-1:0] active_q;

	// item latch
	logic [tmhq_pkg::IW-1:0] id_q;
	logic [62:0] now_q;
	tmhq_pkg::entry_t new_q;     // entry being pushed
	tmhq_pkg::entry_t top_q;     // popped top / last entry during pop
	tmhq_pkg::entry_t c1_q;
	logic [HW-1:0] idx_q;        // hole position
	logic [HW-1:0] cidx_q;       // chosen child
	logic          c2ok_q;
	logic [HW-1:0] scan_q;
	logic [3:0]    st_q;
	logic          fired_q;
	logic [7:0]    fid_q;
	logic          rearm_q;

	// ram port
	logic          we;
	logic [HW-1:0] addr;
	tmhq_pkg::entry_t wdata, rdata;
	logic [tmhq_pkg::EW-1:0] rraw;
	assign rdata = tmhq_pkg::entry_t'(rraw);

	tmhq_ram #(.DEPTH(tmhq_pkg::HEAP_DEPTH), .WIDTH(tmhq_pkg::EW)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rraw)
	);

	// ms to ns product terms, one multiply per cycle
	logic [33:0] msum;
	logic [63:0] mprod;
	assign msum  = {2'b00, delay_ms} + {2'b00, interval_ms};
	assign mprod = 64'({30'd0, msum} * 64'd1000000);

	logic [SW:0] c1w;
	assign c1w = {1'b0, idx_q, 1'b1} ;

	assign in_ready = (state_q == S_IDLE) && !out_valid;
	assign status   = st_q;
	assign fired    = fired_q;
	assign fired_id = fid_q;

	// ram address and write control
	always_comb begin
		we    = 1'b0;
		addr  = idx_q;
		wdata = new_q;
		case (state_q)
			S_UPRD:  addr = HW'((idx_q - 1'b1) >> 1);
			S_UPCMP: begin
				if (idx_q != '0 && new_q.expiry < rdata.expiry) begin
					we = 1'b1; wdata = rdata;
				end else begin
					we = 1'b1; wdata = new_q;
				end
			end
			S_STRD:  addr = scan_q;
			S_STCMP: begin
				addr = scan_q;
				if (rdata.timer == 8'(id_q) && !rdata.stopped) begin
					we = 1'b1; wdata = rdata; wdata.stopped = 1'b1;
				end
			end
			S_TKRD:  addr = '0;
			S_LSTRD: addr = HW'(size_q);
			S_DNC1:  addr = HW'(c1w);
			S_DNRD2: addr = HW'(c1w + 1'b1);
			S_DNCP:  begin we = 1'b1; wdata = c1_q; end
			S_DNDEC: begin we = 1'b1; wdata = top_q; end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			size_q    <= '0;
			active_q  <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					rearm_q <= 1'b0;
					id_q    <= timer_id[tmhq_pkg::IW-1:0];
					now_q   <= now_ns;
					fired_q <= 1'b0;
					fid_q   <= '0;
					new_q.timer     <= 8'(timer_id[tmhq_pkg::IW-1:0]);
					new_q.remaining <= repeat_count;
					new_q.period    <= interval_ms;
					new_q.stopped   <= 1'b0;
					new_q.expiry    <= mprod;
					scan_q <= '0;
					if (mode == tmhq_pkg::MODE_ADD) state_q <= S_ADD;
					else if (mode == tmhq_pkg::MODE_STOP) begin
						st_q <= tmhq_pkg::ST_UNKNOWN;
						if (active_q[timer_id[tmhq_pkg::IW-1:0]] && size_q != '0)
							state_q <= S_STRD;
						else state_q <= S_OUT;
					end else begin
						if (size_q == '0) begin
							st_q <= tmhq_pkg::ST_NOT_DUE; state_q <= S_OUT;
						end else state_q <= S_TKRD;
					end
				end
				S_ADD: begin
					if (!rearm_q && size_q >= SW'(tmhq_pkg::HEAP_DEPTH)) begin
						st_q <= tmhq_pkg::ST_FULL; state_q <= S_OUT;
					end else if (!rearm_q && active_q[id_q]) begin
						st_q <= tmhq_pkg::ST_ACTIVE; state_q <= S_OUT;
					end else begin
						// re-arm push bypasses the full and active checks
						new_q.expiry <= new_q.expiry + {1'b0, now_q};
						if (!rearm_q) begin
							active_q[id_q] <= 1'b1;
							st_q <= tmhq_pkg::ST_ADDED;
						end
						idx_q  <= HW'(size_q);
						size_q <= size_q + 1'b1;
						state_q <= S_UPRD;
					end
				end
				S_UPRD: state_q <= S_UPCMP;
				S_UPCMP: begin
					if (idx_q != '0 && new_q.expiry < rdata.expiry) begin
						idx_q <= HW'((idx_q - 1'b1) >> 1);
						state_q <= S_UPRD;
					end else state_q <= S_OUT;
				end
				S_STRD: state_q <= S_STCMP;
				S_STCMP: begin
					if (rdata.timer == 8'(id_q) && !rdata.stopped) begin
						active_q[id_q] <= 1'b0;
						st_q <= tmhq_pkg::ST_STOPPED;
						state_q <= S_OUT;
					end else if (SW'(scan_q) + 1'b1 >= size_q) state_q <= S_OUT;
					else begin
						scan_q <= scan_q + 1'b1;
						state_q <= S_STRD;
					end
				end
				S_TKRD: state_q <= S_TKCMP;
				S_TKCMP: begin
					if ({1'b0, now_q} < rdata.expiry) begin
						st_q <= tmhq_pkg::ST_NOT_DUE; state_q <= S_OUT;
					end else begin
						top_q <= rdata;
						new_q <= rdata;
						fid_q <= rdata.timer;
						size_q <= size_q - 1'b1;
						idx_q <= '0;
						if (size_q == SW'(1)) state_q <= S_AFTER;
						else state_q <= S_LSTRD;
					end
				end
				S_LSTRD: state_q <= S_LSTGT;
				S_LSTGT: begin
					top_q <= rdata;     // last entry fills the hole
					if (SW'(c1w) >= size_q) state_q <= S_DNDEC;
					else state_q <= S_DNC1;
				end
				S_DNC1: state_q <= S_DNRD2;
				S_DNRD2: begin
					c1_q <= rdata; cidx_q <= HW'(c1w);
					c2ok_q <= (SW'(c1w) + 1'b1) < size_q;
					state_q <= S_DNC2;
				end
				S_DNC2: begin
					if (c2ok_q && c1_q.expiry > rdata.expiry) begin
						c1_q <= rdata; cidx_q <= HW'(c1w + 1'b1);
						if (rdata.expiry < top_q.expiry) state_q <= S_DNCP;
						else state_q <= S_DNDEC;
					end else if (c1_q.expiry < top_q.expiry) state_q <= S_DNCP;
					else state_q <= S_DNDEC;
				end
				S_DNCP: begin
					idx_q <= cidx_q;
					if ((({1'b0, cidx_q, 1'b1}) >= {1'b0, size_q}))
						state_q <= S_DNDEC;
					else state_q <= S_DNC1;
				end
				S_DNDEC: state_q <= S_AFTER;
				S_AFTER: begin
					// new_q holds the popped entry here
					if (new_q.stopped) begin
						st_q <= tmhq_pkg::ST_DISCARDED; state_q <= S_OUT;
					end else if (new_q.remaining == '0) begin
						active_q[new_q.timer[tmhq_pkg::IW-1:0]] <= 1'b0;
						st_q <= tmhq_pkg::ST_DISCARDED; state_q <= S_OUT;
					end else begin
						fired_q <= 1'b1;
						if (new_q.remaining == 17'd1) begin
							active_q[new_q.timer[tmhq_pkg::IW-1:0]] <= 1'b0;
							st_q <= tmhq_pkg::ST_FINAL; state_q <= S_OUT;
						end else begin
							if (!new_q.remaining[16])
								new_q.remaining <= new_q.remaining - 1'b1;
							new_q.expiry <= 64'({32'd0, new_q.period} * 64'd1000000);
							rearm_q <= 1'b1;
							st_q <= tmhq_pkg::ST_REARMED;
							state_q <= S_ADD;
						end
					end
				end
				S_OUT: begin
					out_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> verif/timer_min_heap_queue_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_min_heap_queue_checker
// watches both channels of the timer heap queue, keeps its own copy of the
// heap and id table, predicts one result per input transaction and compares
// ----------------------------------------------------------------------------
module timer_min_heap_queue_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [7:0]  timer_id,
	input  logic [31:0] delay_ms,
	input  logic [31:0] interval_ms,
	input  logic signed [16:0] repeat_count,
	input  logic [62:0] now_ns,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [3:0]  status,
	input  logic        fired,
	input  logic [7:0]  fired_id,
	output int          fail_count,
	output int          pending
);

	localparam logic [63:0] NS_PER_MS = 64'd1000000;

	typedef struct {
		logic [3:0] status;
		logic       fired;
		logic [7:0] fired_id;
	} outcome_t;

	tmhq_pkg::entry_t heap [tmhq_pkg::HEAP_DEPTH];
	int       heap_count;
	bit       id_busy [tmhq_pkg::TIMER_IDS];
	outcome_t outcome_q [$];

	assign pending = outcome_q.size();

	task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
		$display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	// insert and sift up; an entry rises only past a strictly later parent
	function automatic void heap_insert(input tmhq_pkg::entry_t e);
		int i;
		i = heap_count;
		heap_count++;
		while (i != 0 && e.expiry < heap[(i - 1) / 2].expiry) begin
			heap[i] = heap[(i - 1) / 2];
			i = (i - 1) / 2;
		end
		heap[i] = e;
	endfunction

	// remove the top and sift the last entry down
	function automatic void heap_remove_top();
		int i, c, n;
		tmhq_pkg::entry_t last;
		i = 0;
		heap_count--;
		n = heap_count;
		if (n == 0)
			return;
		last = heap[n];
		forever begin
			c = 2 * i + 1;
			if (c >= n)
				break;
			if (c + 1 < n && heap[c].expiry > heap[c + 1].expiry)
				c++;
			if (heap[c].expiry < last.expiry) begin
				heap[i] = heap[c];
				i = c;
			end else begin
				break;
			end
		end
		heap[i] = last;
	endfunction

	function automatic outcome_t predict_outcome(input logic [1:0] m, input logic [7:0] id,
			input logic [31:0] dly, input logic [31:0] ivl, input logic [16:0] rc,
			input logic [62:0] now);
		outcome_t r;
		tmhq_pkg::entry_t e, top;
		logic [63:0] t_now;
		t_now = {1'b0, now};
		r = '{status: tmhq_pkg::ST_NOT_DUE, fired: 1'b0, fired_id: 8'd0};
		if (m == tmhq_pkg::MODE_ADD) begin
			if (heap_count >= tmhq_pkg::HEAP_DEPTH) begin
				r.status = tmhq_pkg::ST_FULL;
			end else if (id_busy[id]) begin
				r.status = tmhq_pkg::ST_ACTIVE;
			end else begin
				e.expiry    = t_now + (64'(dly) + 64'(ivl)) * NS_PER_MS;
				e.timer     = id;
				e.remaining = rc;
				e.period    = ivl;
				e.stopped   = 1'b0;
				heap_insert(e);
				id_busy[id] = 1'b1;
				r.status = tmhq_pkg::ST_ADDED;
			end
		end else if (m == tmhq_pkg::MODE_STOP) begin
			r.status = tmhq_pkg::ST_UNKNOWN;
			if (id_busy[id]) begin
				for (int i = 0; i < heap_count; i++) begin
					if (heap[i].timer == id && !heap[i].stopped) begin
						heap[i].stopped = 1'b1;
						id_busy[id] = 1'b0;
						r.status = tmhq_pkg::ST_STOPPED;
						break;
					end
				end
			end
		end else if (heap_count != 0 && t_now >= heap[0].expiry) begin
			// tick with a due top entry; mode 3 lands here too
			top = heap[0];
			r.fired_id = top.timer;
			heap_remove_top();
			if (top.stopped) begin
				r.status = tmhq_pkg::ST_DISCARDED;
			end else if (top.remaining == 17'd0) begin
				id_busy[top.timer] = 1'b0;
				r.status = tmhq_pkg::ST_DISCARDED;
			end else begin
				r.fired = 1'b1;
				if (!top.remaining[16])
					top.remaining = top.remaining - 17'd1;
				if (top.remaining == 17'd0) begin
					id_busy[top.timer] = 1'b0;
					r.status = tmhq_pkg::ST_FINAL;
				end else begin
					top.expiry = t_now + 64'(top.period) * NS_PER_MS;
					heap_insert(top);
					r.status = tmhq_pkg::ST_REARMED;
				end
			end
		end
		return r;
	endfunction

	// predict on input transactions, compare on output transactions
	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			heap_count = 0;
			foreach (id_busy[i])
				id_busy[i] = 1'b0;
			outcome_q.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (outcome_q.size() == 0) begin
					$display("%0t mismatch: result with nothing expected", $realtime);
					fail_count++;
				end else begin
					want = outcome_q.pop_front();
					if (status !== want.status)
						report("status", 8'(status), 8'(want.status));
					if (fired !== want.fired)
						report("fired", 8'(fired), 8'(want.fired));
					if (fired_id !== want.fired_id)
						report("fired_id", fired_id, want.fired_id);
				end
			end
			if (in_valid && in_ready)
				outcome_q.insert(outcome_q.size(), predict_outcome(mode, timer_id,
					delay_ms, interval_ms, repeat_count, now_ns));
		end
	end

	initial fail_count = 0;

endmodule

>>> verif/tb_timer_min_heap_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timer_min_heap_queue
// drives add, stop and tick transactions into the timer heap queue with
// bursty input and a stalling receiver; the checker predicts and compares
// ----------------------------------------------------------------------------
module tb_timer_min_heap_queue;

	localparam logic [1:0] MODE_TICK  = 2'd2;
	localparam logic [1:0] MODE_ODD   = 2'd3;
	localparam int         N_ITEMS    = 1350;
	localparam int         IDLE_LIMIT = 5000;
	localparam logic [62:0] NOW_MAX   = '1;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  mode;
	logic [7:0]  timer_id;
	logic [31:0] delay_ms;
	logic [31:0] interval_ms;
	logic signed [16:0] repeat_count;
	logic [62:0] now_ns;
	logic        out_valid;
	logic        out_ready;
	logic [3:0]  status;
	logic        fired;
	logic [7:0]  fired_id;
	int          fail_count;
	int          pending;

	int          burst_left;
	logic [62:0] clock_ns;
	int          idle_cycles;
	int          stall_kind;

	timer_min_heap_queue i_dut (.*);

	timer_min_heap_queue_checker i_checker (.*);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// receiver stall pattern, whose character changes at random
	always @(posedge clk) begin
		if (($urandom % 64) == 0)
			stall_kind <= $urandom_range(0, 3);
		case (stall_kind)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= (($urandom % 4) == 0);
			default: out_ready <= ~out_ready;
		endcase
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// present one transaction and hold it until accepted; gaps fall between bursts
	task automatic send_timer_op(input logic [1:0] m, input logic [7:0] id,
			input logic [31:0] dly, input logic [31:0] ivl, input logic [16:0] rc,
			input logic [62:0] now);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom % 5 == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
		end
		burst_left--;
		in_valid     <= 1'b1;
		mode         <= m;
		timer_id     <= id;
		delay_ms     <= dly;
		interval_ms  <= ivl;
		repeat_count <= rc;
		now_ns       <= now;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// random add parameters: mostly short timers, sometimes full-range values
	task automatic send_random_add(input int id_span);
		logic [31:0] dly, ivl;
		logic [16:0] rc;
		logic [62:0] now;
		dly = ($urandom % 20 == 0) ? $urandom : $urandom_range(0, 3);
		ivl = ($urandom % 20 == 0) ? $urandom : $urandom_range(0, 3);
		case ($urandom_range(0, 9))
			0: rc = -17'sd1;
			1: rc = 17'd0;
			2: rc = 17'($urandom);
			default: rc = 17'($urandom_range(1, 4));
		endcase
		now = ($urandom % 50 == 0) ? 63'({$urandom, $urandom}) : clock_ns;
		send_timer_op(tmhq_pkg::MODE_ADD, 8'($urandom_range(0, id_span)), dly, ivl, rc, now);
	endtask

	initial begin
		int sent;
		int fill_phase;
		int pick;
		logic [62:0] now;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		mode         = tmhq_pkg::MODE_ADD;
		timer_id     = '0;
		delay_ms     = '0;
		interval_ms  = '0;
		repeat_count = '0;
		now_ns       = '0;
		out_ready    = 1'b0;
		stall_kind   = 0;
		idle_cycles  = 0;
		burst_left   = 0;
		clock_ns     = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty heap, unknown stop, duplicate add, odd mode as tick
		send_timer_op(MODE_TICK, 8'd0, '0, '0, 17'd0, '0);
		send_timer_op(tmhq_pkg::MODE_STOP, 8'd7, '0, '0, 17'd0, '0);
		send_timer_op(tmhq_pkg::MODE_ADD, 8'd0, '0, '0, 17'd1, '0);
		send_timer_op(tmhq_pkg::MODE_ADD, 8'd0, '0, '0, 17'd3, '0);
		send_timer_op(MODE_ODD, 8'd0, '0, '0, 17'd0, '0);
		// extremes of delay, interval and counts, ties on expiry
		send_timer_op(tmhq_pkg::MODE_ADD, 8'd255, '1, '1, -17'sd1, '0);
		send_timer_op(tmhq_pkg::MODE_ADD, 8'd1, '0, '0, 17'd0, 63'd10);
		send_timer_op(tmhq_pkg::MODE_ADD, 8'd2, '0, 32'd1, -17'sd2, 63'd10);
		send_timer_op(tmhq_pkg::MODE_ADD, 8'd3, '0, '0, 17'd65535, 63'd10);
		send_timer_op(tmhq_pkg::MODE_ADD, 8'd4, '0, 32'd2, 17'h10000, 63'd10);
		// stop releases the id; re-add while the stopped entry still waits
		send_timer_op(tmhq_pkg::MODE_STOP, 8'd4, '0, '0, 17'd0, '0);
		send_timer_op(tmhq_pkg::MODE_ADD, 8'd4, '0, 32'd1, 17'd2, 63'd10);
		send_timer_op(tmhq_pkg::MODE_STOP, 8'd4, '0, '0, 17'd0, '0);
		send_timer_op(MODE_TICK, 8'd0, '0, '0, 17'd0, 63'd5);
		send_timer_op(MODE_TICK, 8'd0, '0, '0, 17'd0, 63'd10);
		send_timer_op(MODE_TICK, 8'd0, '0, '0, 17'd0, 63'd10);
		send_timer_op(MODE_TICK, 8'd0, '0, '0, 17'd0, 63'd10);
		send_timer_op(MODE_TICK, 8'd0, '0, '0, 17'd0, 63'd2000010);
		send_timer_op(MODE_TICK, 8'd0, '0, '0, 17'd0, 63'd3000010);
		send_timer_op(MODE_TICK, 8'd0, '0, '0, 17'd0, 63'd3000010);
		send_timer_op(tmhq_pkg::MODE_ADD, 8'd200, '1, 32'd5, 17'd1, NOW_MAX);
		send_timer_op(tmhq_pkg::MODE_STOP, 8'd255, '0, '0, 17'd0, '0);
		send_timer_op(MODE_TICK, 8'd0, '0, '0, 17'd0, NOW_MAX);
		send_timer_op(MODE_TICK, 8'd0, '0, '0, 17'd0, NOW_MAX);
		send_timer_op(MODE_ODD, 8'd3, '1, '1, 17'd0, NOW_MAX);

		// random: alternate fill phases (heap reaches full) and drain phases
		sent = 0;
		fill_phase = 1;
		clock_ns = 63'd4000000;
		while (sent < N_ITEMS) begin
			if (sent % 100 == 0)
				fill_phase = $urandom_range(0, 2);
			pick = $urandom_range(0, 99);
			if (fill_phase == 1 ? pick < 75 : pick < 35) begin
				send_random_add(fill_phase == 1 ? 255 : 15);
			end else if (pick < (fill_phase == 1 ? 85 : 50)) begin
				send_timer_op(tmhq_pkg::MODE_STOP,
					8'($urandom_range(0, fill_phase == 1 ? 255 : 15)),
					$urandom, $urandom, 17'($urandom), 63'($urandom));
			end else begin
				clock_ns = clock_ns + 63'($urandom_range(0, 2000000));
				case ($urandom_range(0, 49))
					0: now = NOW_MAX;
					1: now = 63'({$urandom, $urandom});
					default: now = clock_ns;
				endcase
				send_timer_op(($urandom % 10 == 0) ? MODE_ODD : MODE_TICK,
					8'($urandom), $urandom, $urandom, 17'($urandom), now);
			end
			sent++;
		end
		in_valid <= 1'b0;

		// drain and settle
		while (pending != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
